// ===== src/wfl_pkg.sv =====
package wfl_pkg;

	// Field widths
	localparam int COORD_W = 16;             // coordinates and register data
	localparam int ANG_W   = 16;             // binary angle, 65536 per turn
	localparam int D_W     = COORD_W + 1;    // wall edge vector and normal
	localparam int P_W     = COORD_W + 3;    // doubled midpoint-to-viewer vector
	localparam int PROD_W  = P_W + D_W;      // one term of the dot product
	localparam int DOT_W   = PROD_W + 1;     // dot product
	localparam int FRAC_W  = 16;             // fraction bits of the rotator
	localparam int CX_W    = D_W + FRAC_W + 3; // rotator word, room for gain
	localparam int ACC_W   = 32;             // angle accumulator, 2^32 per turn

	// Rotator length
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	// atan(2^-i) as a fraction of a turn, 2^32 per turn
	localparam logic [ACC_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam logic [ACC_W-1:0] HALF_TURN  = ACC_W'(1) << (ACC_W - 1);
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ACC_W - ANG_W - 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	typedef logic [COORD_W-1:0] cfg_data_t;

	localparam cfg_index_t REG_SEG_A_X = 2'd0;
	localparam cfg_index_t REG_SEG_A_Y = 2'd1;
	localparam cfg_index_t REG_SEG_B_X = 2'd2;
	localparam cfg_index_t REG_SEG_B_Y = 2'd3;

	// Channel payloads
	typedef struct packed {
		logic signed [COORD_W-1:0] viewer_x;
		logic signed [COORD_W-1:0] viewer_y;
		logic [ANG_W-1:0]          light_angle;
	} view_item_t;

	typedef struct packed {
		logic [ANG_W-1:0] shade_factor;
		logic             degenerate;
	} shade_item_t;

endpackage

// ===== src/wfl_channels.sv =====
interface wfl_view_if;
	import wfl_pkg::*;

	logic       valid;
	logic       ready;
	view_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wfl_shade_if;
	import wfl_pkg::*;

	logic        valid;
	logic        ready;
	shade_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/wall_face_light_shading.sv =====
// Channel     Dir  Payload                                 Handshake
// item_in     in   viewer_x, viewer_y, light_angle         valid/ready
// result_out  out  shade_factor, degenerate                valid/ready
// cfg_*       in   cfg_index, cfg_data (seg_a/seg_b x,y)   cfg_we, no wait
//
// One transaction per cycle unless the output stalls; a result passes through
// stages 1, 2 and 3, one rotator stage per step and the output register.
// arst_n clears the wall registers and all stage valid bits.
// A stalled output freezes the whole pipeline; item_in.ready stays high
// while the output register is empty or being taken.
module wall_face_light_shading (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  wfl_pkg::cfg_index_t cfg_index,
	input  wfl_pkg::cfg_data_t  cfg_data,
	wfl_view_if.sink            item_in,
	wfl_shade_if.source         result_out
);
	import wfl_pkg::*;

	// Wall endpoints
	logic signed [COORD_W-1:0] seg_ax_q, seg_ay_q, seg_bx_q, seg_by_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_ax_q <= '0;
			seg_ay_q <= '0;
			seg_bx_q <= '0;
			seg_by_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEG_A_X: seg_ax_q <= cfg_data;
				REG_SEG_A_Y: seg_ay_q <= cfg_data;
				REG_SEG_B_X: seg_bx_q <= cfg_data;
				REG_SEG_B_Y: seg_by_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance: move everything when the output slot frees up
	logic adv;
	assign adv           = !result_out.valid || result_out.ready;
	assign item_in.ready = adv;

	// Stage 1: edge vector and doubled midpoint-to-viewer vector
	logic signed [D_W-1:0] dx, dy;
	logic signed [P_W-1:0] px, py;

	always_comb begin
		dx = D_W'(seg_bx_q) - D_W'(seg_ax_q);
		dy = D_W'(seg_by_q) - D_W'(seg_ay_q);
		px = (P_W'(item_in.data.viewer_x) <<< 1) - (P_W'(seg_ax_q) <<< 1) - P_W'(dx);
		py = (P_W'(item_in.data.viewer_y) <<< 1) - (P_W'(seg_ay_q) <<< 1) - P_W'(dy);
	end

	logic                  vld_s1;
	logic signed [D_W-1:0] nx_s1, ny_s1;
	logic signed [P_W-1:0] px_s1, py_s1;
	logic [ANG_W-1:0]      light_s1;
	logic                  degen_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1    <= -dy;
			ny_s1    <= dx;
			px_s1    <= px;
			py_s1    <= py;
			light_s1 <= item_in.data.light_angle;
			degen_s1 <= (dx == '0) && (dy == '0);
		end
	end

	// Stage 2: dot product terms
	logic                     vld_s2;
	logic signed [D_W-1:0]    nx_s2, ny_s2;
	logic signed [PROD_W-1:0] prod_x_s2, prod_y_s2;
	logic [ANG_W-1:0]         light_s2;
	logic                     degen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s2     <= nx_s1;
			ny_s2     <= ny_s1;
			prod_x_s2 <= PROD_W'(px_s1) * PROD_W'(nx_s1);
			prod_y_s2 <= PROD_W'(py_s1) * PROD_W'(ny_s1);
			light_s2  <= light_s1;
			degen_s2  <= degen_s1;
		end
	end

	// Stage 3: pick the facing normal and fold it into the right half plane.
	// Both negations collapse into one: flip when exactly one of them applies.
	logic signed [DOT_W-1:0] dot;
	logic                    face_neg, x_neg, flip;
	logic signed [D_W-1:0]   fx, fy;

	always_comb begin
		dot      = DOT_W'(prod_x_s2) + DOT_W'(prod_y_s2);
		face_neg = !(dot > 0);
		x_neg    = face_neg ? (nx_s2 > 0) : (nx_s2 < 0);
		flip     = face_neg ^ x_neg;
		fx       = flip ? -nx_s2 : nx_s2;
		fy       = flip ? -ny_s2 : ny_s2;
	end

	// Rotator pipeline; index 0 is the stage 3 register, index k+1 follows step k
	logic                    vld_s   [0:ITERS];
	logic signed [CX_W-1:0]  cx_s    [0:ITERS];
	logic signed [CX_W-1:0]  cy_s    [0:ITERS];
	logic [ACC_W-1:0]        acc_s   [0:ITERS];
	logic [ANG_W-1:0]        light_s [0:ITERS];
	logic                    degen_s [0:ITERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0]    <= CX_W'(fx) <<< FRAC_W;
			cy_s[0]    <= CX_W'(fy) <<< FRAC_W;
			acc_s[0]   <= x_neg ? HALF_TURN : '0;
			light_s[0] <= light_s2;
			degen_s[0] <= degen_s2;
		end
	end

	for (genvar k = 0; k < ITERS; k++) begin : g_iter
		logic signed [CX_W-1:0] xs, ys;
		logic                   y_pos;

		always_comb begin
			xs    = cx_s[k] >>> k;
			ys    = cy_s[k] >>> k;
			y_pos = cy_s[k] > 0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		// Rotate toward the x axis and accumulate the step angle
		always_ff @(posedge clk) begin
			if (adv) begin
				if (y_pos) begin
					cx_s[k+1]  <= cx_s[k] + ys;
					cy_s[k+1]  <= cy_s[k] - xs;
					acc_s[k+1] <= acc_s[k] + ATAN_TURNS[k];
				end else begin
					cx_s[k+1]  <= cx_s[k] - ys;
					cy_s[k+1]  <= cy_s[k] + xs;
					acc_s[k+1] <= acc_s[k] - ATAN_TURNS[k];
				end
				light_s[k+1] <= light_s[k];
				degen_s[k+1] <= degen_s[k];
			end
		end
	end

	// Output stage: round to a 16-bit angle, wrap the difference, take magnitude
	logic [ACC_W-1:0] acc_rnd;
	logic [ANG_W-1:0] ang, diff, mag;

	always_comb begin
		acc_rnd = acc_s[ITERS] + ROUND_HALF;
		ang     = acc_rnd[ACC_W-1 -: ANG_W];
		diff    = ang - light_s[ITERS];
		mag     = diff[ANG_W-1] ? (ANG_W'(0) - diff) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_out.valid <= 1'b0;
		end else if (adv) begin
			result_out.valid <= vld_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_out.data.shade_factor <= degen_s[ITERS] ? '0 : mag;
			result_out.data.degenerate   <= degen_s[ITERS];
		end
	end

endmodule

// ===== verif/tb_wall_face_light_shading.sv =====
module tb_wall_face_light_shading;
	timeunit 1ns;
	timeprecision 1ps;

	import wfl_pkg::*;

	localparam int ROTATOR_STEPS = 16;
	localparam int ATAN_COUNT    = 24;
	localparam int STEPS_RUN     = (ROTATOR_STEPS < ATAN_COUNT) ? ROTATOR_STEPS : ATAN_COUNT;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 103;
	localparam int HOLD_CYCLES   = 150;
	localparam int MAX_REPORTS   = 10;

	// atan(2^-i) in turns, 2^32 per turn
	localparam logic [31:0] ATAN_STEP [ATAN_COUNT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	wfl_view_if  view_ch ();
	wfl_shade_if shade_ch ();

	wall_face_light_shading i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_in    (view_ch),
		.result_out (shade_ch)
	);

	// Wall registers as last written
	longint wall_ax, wall_ay, wall_bx, wall_by;

	view_item_t  pending_views [$];
	shade_item_t expected_shades [$];

	int unsigned views_accepted;
	int unsigned mismatch_count;
	int unsigned view_gap;
	int unsigned shade_gap;
	bit          view_taken;
	bit          shade_taken;
	bit          view_idle_on;
	bit          shade_idle_on;
	bit          hold_off;
	view_item_t  next_view;
	logic        next_view_valid;
	shade_item_t shade_want;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Angle of a normal vector as a 16-bit binary angle, vectoring rotator
	function automatic logic [ANG_W-1:0] normal_bam(longint nx, longint ny);
		longint      x;
		longint      y;
		longint      xs;
		longint      ys;
		logic [31:0] turn;
		logic [31:0] rounded;
		x = nx * 65536;
		y = ny * 65536;
		turn = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			turn = 32'h8000_0000;
		end
		for (int i = 0; i < STEPS_RUN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				turn = turn + ATAN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				turn = turn - ATAN_STEP[i];
			end
		end
		rounded = turn + 32'h0000_8000;
		return rounded[31:16];
	endfunction

	// Angle of the wall normal that faces the viewer (wall must have length)
	function automatic logic [ANG_W-1:0] facing_bam(logic signed [COORD_W-1:0] vx,
			logic signed [COORD_W-1:0] vy);
		longint dx;
		longint dy;
		longint nx;
		longint ny;
		longint px;
		longint py;
		longint dot;
		dx = wall_bx - wall_ax;
		dy = wall_by - wall_ay;
		nx = -dy;
		ny = dx;
		px = 2 * longint'(vx) - 2 * wall_ax - dx;
		py = 2 * longint'(vy) - 2 * wall_ay - dy;
		dot = px * nx + py * ny;
		if (!(dot > 0)) begin
			nx = -nx;
			ny = -ny;
		end
		return normal_bam(nx, ny);
	endfunction

	function automatic bit wall_is_point();
		return (wall_ax == wall_bx) && (wall_ay == wall_by);
	endfunction

	function automatic shade_item_t shade_of_view(view_item_t v);
		shade_item_t      res;
		logic [ANG_W-1:0] diff;
		logic [ANG_W:0]   mag;
		res = '0;
		if (wall_is_point()) begin
			res.degenerate = 1'b1;
			return res;
		end
		diff = facing_bam(v.viewer_x, v.viewer_y) - v.light_angle;
		mag = diff[ANG_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
		res.shade_factor = mag[ANG_W-1:0];
		return res;
	endfunction

	function automatic int unsigned draw_gap(bit on);
		return on ? $urandom_range(7, 0) : 0;
	endfunction

	task automatic offer_view(logic [15:0] vx, logic [15:0] vy, logic [15:0] light);
		view_item_t v;
		v.viewer_x    = vx;
		v.viewer_y    = vy;
		v.light_angle = light;
		pending_views.push_back(v);
	endtask

	task automatic write_wall_reg(cfg_index_t idx, cfg_data_t val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SEG_A_X: wall_ax = longint'($signed(val));
			REG_SEG_A_Y: wall_ay = longint'($signed(val));
			REG_SEG_B_X: wall_bx = longint'($signed(val));
			REG_SEG_B_Y: wall_by = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic set_wall(cfg_data_t ax, cfg_data_t ay, cfg_data_t bx, cfg_data_t by);
		write_wall_reg(REG_SEG_A_X, ax);
		write_wall_reg(REG_SEG_A_Y, ay);
		write_wall_reg(REG_SEG_B_X, bx);
		write_wall_reg(REG_SEG_B_Y, by);
		@(posedge clk);
	endtask

	// Wait until every offered view has come back as a shade, then let the pipe settle
	task automatic drain();
		while (pending_views.size() > 0 || view_ch.valid || expected_shades.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic cfg_data_t pick_extreme();
		case ($urandom_range(3, 0))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return cfg_data_t'($urandom());
		endcase
	endfunction

	// Choose a wall for one random phase
	task automatic random_wall(int phase);
		cfg_data_t ax;
		cfg_data_t ay;
		cfg_data_t bx;
		cfg_data_t by;
		ax = cfg_data_t'($urandom());
		ay = cfg_data_t'($urandom());
		bx = cfg_data_t'($urandom());
		by = cfg_data_t'($urandom());
		case (phase % 5)
			1: begin
				bx = ax + cfg_data_t'($urandom_range(32, 0)) - 16'd16;
				by = ay + cfg_data_t'($urandom_range(32, 0)) - 16'd16;
			end
			2: begin
				ax = pick_extreme();
				ay = pick_extreme();
				bx = pick_extreme();
				by = pick_extreme();
			end
			3: begin
				bx = ax;
				by = ay;
			end
			4: begin
				if ($urandom_range(1, 0))
					bx = ax;
				else
					by = ay;
			end
			default: ;
		endcase
		set_wall(ax, ay, bx, by);
	endtask

	// One random view, mostly spread over the plane, some on or near the wall
	task automatic random_view();
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] light;
		int unsigned kind;
		kind = $urandom_range(9, 0);
		vx = 16'($urandom());
		vy = 16'($urandom());
		case (kind)
			0: begin
				vx = 16'(wall_ax);
				vy = 16'(wall_ay);
			end
			1: begin
				vx = 16'(wall_bx);
				vy = 16'(wall_by);
			end
			2, 3: begin
				vx = 16'(((wall_ax + wall_bx) >>> 1) + $urandom_range(6, 0) - 3);
				vy = 16'(((wall_ay + wall_by) >>> 1) + $urandom_range(6, 0) - 3);
			end
			default: ;
		endcase
		light = 16'($urandom());
		if (!wall_is_point()) begin
			case ($urandom_range(7, 0))
				0: light = facing_bam(vx, vy);
				1: light = facing_bam(vx, vy) + 16'h8000;
				default: ;
			endcase
		end
		offer_view(vx, vy, light);
	endtask

	// Record accepted views and their expected shades
	always @(posedge clk) begin
		if (arst_n && view_ch.valid && view_ch.ready) begin
			expected_shades.push_back(shade_of_view(view_ch.data));
			views_accepted++;
			view_taken = 1'b1;
		end
	end

	// Offer views from the pending queue, with a random gap after each transaction
	always @(negedge clk) begin
		next_view_valid = view_ch.valid;
		next_view       = view_ch.data;
		if (next_view_valid && view_taken) begin
			next_view_valid = 1'b0;
			view_gap = draw_gap(view_idle_on);
		end
		view_taken = 1'b0;
		if (!next_view_valid) begin
			if (view_gap > 0)
				view_gap--;
			else if (pending_views.size() > 0) begin
				next_view_valid = 1'b1;
				next_view = pending_views.pop_front();
			end
		end
		view_ch.valid <= next_view_valid;
		view_ch.data  <= next_view;
	end

	// Drive ready; drop it for a random gap after each transaction and while held off
	always @(negedge clk) begin
		if (shade_taken) begin
			shade_taken = 1'b0;
			shade_gap = draw_gap(shade_idle_on);
		end
		if (hold_off)
			shade_ch.ready <= 1'b0;
		else if (shade_gap > 0) begin
			shade_gap--;
			shade_ch.ready <= 1'b0;
		end else begin
			shade_ch.ready <= 1'b1;
		end
	end

	task automatic note_mismatch(string what, shade_item_t want, shade_item_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s: expected factor %0d degenerate %0d, got factor %0d degenerate %0d",
				$realtime, what, want.shade_factor, want.degenerate,
				got.shade_factor, got.degenerate);
	endtask

	// Check each shade against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && shade_ch.valid && shade_ch.ready) begin
			shade_taken = 1'b1;
			if (expected_shades.size() == 0)
				note_mismatch("shade with nothing outstanding", '0, shade_ch.data);
			else begin
				shade_want = expected_shades.pop_front();
				if (shade_ch.data.shade_factor !== shade_want.shade_factor)
					note_mismatch("shade_factor", shade_want, shade_ch.data);
				else if (shade_ch.data.degenerate !== shade_want.degenerate)
					note_mismatch("degenerate", shade_want, shade_ch.data);
			end
		end
	end

	// Hold the receiver off for a long stretch while views keep coming
	initial begin
		hold_off = 1'b0;
		do
			@(posedge clk);
		while (!(views_accepted >= 400 && pending_views.size() >= 40));
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_SEG_A_X;
		cfg_data       = '0;
		view_ch.valid  = 1'b0;
		view_ch.data   = '0;
		shade_ch.ready = 1'b0;
		wall_ax        = 0;
		wall_ay        = 0;
		wall_bx        = 0;
		wall_by        = 0;
		views_accepted = 0;
		mismatch_count = 0;
		view_gap       = 0;
		shade_gap      = 0;
		view_taken     = 1'b0;
		shade_taken    = 1'b0;
		view_idle_on   = 1'b1;
		shade_idle_on  = 1'b1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Registers still at reset: zero-length wall
		offer_view(16'h8000, 16'h8000, 16'h0000);
		offer_view(16'h7FFF, 16'h7FFF, 16'hFFFF);
		offer_view(16'h0000, 16'h0000, 16'h8000);
		drain();

		// Ordinary wall: field extremes, midpoint, on the line, half and zero turn
		set_wall(-16'sd100, 16'sd50, 16'sd300, -16'sd70);
		offer_view(16'h8000, 16'h8000, 16'h0000);
		offer_view(16'h7FFF, 16'h7FFF, 16'hFFFF);
		offer_view(16'h8000, 16'h7FFF, 16'h8000);
		offer_view(16'h7FFF, 16'h8000, 16'h7FFF);
		offer_view(16'd100, -16'sd10, 16'h1234);
		offer_view(-16'sd100, 16'sd50, 16'hC000);
		offer_view(16'sd300, -16'sd70, 16'h4000);
		offer_view(16'd0, 16'd1000, facing_bam(16'd0, 16'd1000) + 16'h8000);
		offer_view(16'd0, -16'sd1000, facing_bam(16'd0, -16'sd1000) + 16'h8000);
		offer_view(16'd500, 16'd500, facing_bam(16'd500, 16'd500));
		drain();

		// Both longest diagonal walls, then axis-aligned walls
		set_wall(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		offer_view(16'd5, 16'd5, 16'h0000);
		offer_view(16'h8000, 16'h7FFF, 16'hFFFF);
		offer_view(16'h7FFF, 16'h8000, facing_bam(16'h7FFF, 16'h8000) + 16'h8000);
		drain();
		set_wall(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		offer_view(16'h7FFF, 16'h7FFF, 16'h2000);
		offer_view(16'h8000, 16'h8000, 16'hE000);
		drain();
		set_wall(16'd0, 16'd0, 16'd0, 16'd40);
		offer_view(16'd10, 16'd3, 16'h0000);
		offer_view(-16'sd10, 16'd3, 16'h8000);
		drain();
		set_wall(16'd0, 16'd0, 16'd40, 16'd0);
		offer_view(16'd3, 16'd10, 16'h4000);
		offer_view(16'd3, -16'sd10, 16'hC000);
		drain();

		// Random phases, each with its own wall and idling pattern
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_wall(phase);
			view_idle_on  = (phase % 4 == 1) || (phase % 4 == 2);
			shade_idle_on = (phase % 4 == 1) || (phase % 4 == 3);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_view();
			drain();
		end

		if (mismatch_count == 0 && expected_shades.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
